[rtl/tpsd_pkg.sv]
// ============================================================================
// tpsd_pkg
// Shared types and constants for the tape pulse speed detect and cleanup block.
// ============================================================================
package tpsd_pkg;

	localparam int WINDOW_DEF = 20;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	localparam int PULSE_W = 8;
	localparam int OUT_W   = 72;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_CLEANUP    = 3'd0;
	localparam logic [2:0] CFG_CBM_SHORT  = 3'd1;
	localparam logic [2:0] CFG_CBM_MEDIUM = 3'd2;
	localparam logic [2:0] CFG_CBM_LONG   = 3'd3;
	localparam logic [2:0] CFG_FAST_SHORT = 3'd4;
	localparam logic [2:0] CFG_FAST_LONG  = 3'd5;

	// register reset values
	localparam logic       RST_CLEANUP    = 1'b1;
	localparam logic [7:0] RST_CBM_SHORT  = 8'h2F;
	localparam logic [7:0] RST_CBM_MEDIUM = 8'd66;
	localparam logic [7:0] RST_CBM_LONG   = 8'd86;
	localparam logic [7:0] RST_FAST_SHORT = 8'h1A;
	localparam logic [7:0] RST_FAST_LONG  = 8'd40;

	// tolerances and margins
	localparam logic [8:0] VOTE_MARGIN  = 9'd6;
	localparam logic [8:0] CBM_TOL      = 9'd10;
	localparam logic [8:0] TURBO_TOL    = 9'd7;
	localparam logic [8:0] PAUSE_MARGIN = 9'd9;

	// pause sequence
	localparam logic [7:0] PAUSE_B0 = 8'h00;
	localparam logic [7:0] PAUSE_B1 = 8'h98;
	localparam logic [7:0] PAUSE_B2 = 8'h01;
	localparam logic [7:0] PAUSE_B3 = 8'h05;

	localparam logic [2:0] CNT_NONE  = 3'd0;
	localparam logic [2:0] CNT_ONE   = 3'd1;
	localparam logic [2:0] CNT_PAUSE = 3'd4;

	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_SHORT = 1'b1;

	typedef struct packed {
		logic       cleanup;
		logic [7:0] cbm_short;
		logic [7:0] cbm_medium;
		logic [7:0] cbm_long;
		logic [7:0] fast_short;
		logic [7:0] fast_long;
	} cfg_t;

	// work kinds handed from the front to the back
	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_REPLAY,
		CMD_SHORT,
		CMD_STREAM
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic [7:0]   pulse;
		logic         eor;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_COUNT,
		BK_DECIDE,
		BK_EMIT_RD,
		BK_EMIT
	} back_state_t;

endpackage

[rtl/tpsd_front.sv]
// ============================================================================
// tpsd_front
// Accepts pulses, tracks window fill and phase, and classifies each pulse.
// ============================================================================
module tpsd_front #(
	parameter int WINDOW = tpsd_pkg::WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_pulse,
	input  logic                in_eor,
	input  logic                q_full,
	output logic                push,
	output tpsd_pkg::cmd_t      cmd
);
	import tpsd_pkg::*;

	localparam int FW = $clog2(WINDOW);
	localparam logic [FW-1:0] FILL_LAST = FW'(WINDOW - 1);

	logic [FW-1:0] fill_q;
	logic          streaming_q;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// classify the incoming pulse
	always_comb begin
		cmd.pulse = in_pulse;
		cmd.eor   = in_eor;
		if (streaming_q) begin
			cmd.kind = CMD_STREAM;
		end else if (fill_q == FILL_LAST) begin
			cmd.kind = CMD_REPLAY;
		end else if (in_eor) begin
			cmd.kind = CMD_SHORT;
		end else begin
			cmd.kind = CMD_STORE;
		end
	end

	// advance fill count and phase; drop back to collecting at end of recording
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			streaming_q <= 1'b0;
		end else if (push) begin
			if (in_eor) begin
				fill_q      <= '0;
				streaming_q <= 1'b0;
			end else if (!streaming_q) begin
				if (fill_q == FILL_LAST) begin
					fill_q      <= '0;
					streaming_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/tpsd_queue.sv]
// ============================================================================
// tpsd_queue
// Small command queue between the front and the back.
// ============================================================================
module tpsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tpsd_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output tpsd_pkg::cmd_t  pop_cmd,
	output logic            empty
);
	import tpsd_pkg::*;

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/tpsd_back.sv]
// ============================================================================
// tpsd_back
// Holds the window, votes on speed, replays held pulses, passes later ones through, and cleans them up.
// ============================================================================
module tpsd_back #(
	parameter int WINDOW = tpsd_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpsd_pkg::cfg_t              cfg,
	input  logic                        q_empty,
	input  tpsd_pkg::cmd_t              cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpsd_pkg::OUT_W-1:0]  out_data,
	output logic                        out_last
);
	import tpsd_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW - 1);

	back_state_t state_q, state_d;

	logic [7:0]    mem [WINDOW];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] addr_q;
	logic          cnt_vld_q;
	logic [CW-1:0] nt_q, nn_q;
	logic [CW-1:0] nt_d, nn_d;
	logic          turbo_q;
	logic [31:0]   bytes_q;
	logic          eor_q;

	logic          out_free;
	logic          take;
	logic          mem_we;
	logic          rd_en;
	logic          load_emit;
	logic          load_short;
	logic          emit_last;
	logic          emit_clear;

	logic [7:0]    emit_p;
	logic [8:0]    p9;
	logic [7:0]    snapped;
	logic [7:0]    t_byte;
	logic          is_pause;
	logic [31:0]   bytes_next;
	logic          vote_t, vote_n;

	assign out_free = !out_valid || out_ready;

	// control decode
	always_comb begin
		take       = 1'b0;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		load_emit  = 1'b0;
		load_short = 1'b0;
		emit_last  = 1'b0;
		emit_clear = 1'b0;
		case (state_q)
			BK_IDLE: begin
				take = !q_empty && out_free;
				if (take) begin
					case (cmd.kind)
						CMD_STORE:  mem_we = 1'b1;
						CMD_REPLAY: mem_we = 1'b1;
						CMD_SHORT:  load_short = 1'b1;
						CMD_STREAM: begin
							load_emit  = 1'b1;
							emit_last  = 1'b1;
							emit_clear = cmd.eor;
						end
						default: ;
					endcase
				end
			end
			BK_COUNT:   rd_en = 1'b1;
			BK_EMIT_RD: rd_en = 1'b1;
			BK_EMIT: begin
				if (out_free) begin
					load_emit  = 1'b1;
					emit_last  = (addr_q == ADDR_LAST);
					emit_clear = emit_last && eor_q;
				end
			end
			default: ;
		endcase
	end

	assign pop = take;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take && cmd.kind == CMD_REPLAY) begin
					state_d = BK_COUNT;
				end
			end
			BK_COUNT: begin
				if (addr_q == ADDR_LAST) begin
					state_d = BK_DECIDE;
				end
			end
			BK_DECIDE:  state_d = BK_EMIT_RD;
			BK_EMIT_RD: state_d = BK_EMIT;
			BK_EMIT: begin
				if (load_emit) begin
					state_d = emit_last ? BK_IDLE : BK_EMIT_RD;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// vote on the stored pulse read last cycle
	always_comb begin
		vote_t = ({1'b0, rd_data_q} < ({1'b0, cfg.fast_short} + VOTE_MARGIN));
		vote_n = !vote_t && ({1'b0, rd_data_q} < ({1'b0, cfg.cbm_short} + VOTE_MARGIN));
		nt_d   = nt_q + CW'(vote_t);
		nn_d   = nn_q + CW'(vote_n);
	end

	// snap, force first byte, detect pause
	assign emit_p = (state_q == BK_EMIT) ? rd_data_q : cmd.pulse;
	assign p9     = {1'b0, emit_p};

	always_comb begin
		snapped = emit_p;
		if (cfg.cleanup) begin
			if (!turbo_q) begin
				if ((p9 + CBM_TOL > {1'b0, cfg.cbm_short}) &&
				    (p9 < {1'b0, cfg.cbm_long} + CBM_TOL)) begin
					snapped = cfg.cbm_short;
					if (p9 > {1'b0, cfg.cbm_short} + CBM_TOL) begin
						snapped = cfg.cbm_medium;
						if (p9 > {1'b0, cfg.cbm_medium} + CBM_TOL) begin
							snapped = cfg.cbm_long;
						end
					end
				end
			end else begin
				if ((p9 + TURBO_TOL > {1'b0, cfg.fast_short}) &&
				    (p9 < {1'b0, cfg.fast_long} + TURBO_TOL)) begin
					snapped = cfg.fast_short;
					if (p9 > {1'b0, cfg.fast_short} + TURBO_TOL) begin
						snapped = cfg.fast_long;
					end
				end
			end
		end
		if (bytes_q == '0) begin
			t_byte = turbo_q ? cfg.fast_short : cfg.cbm_short;
		end else begin
			t_byte = snapped;
		end
		is_pause   = ({1'b0, t_byte} > ({1'b0, cfg.cbm_long} + PAUSE_MARGIN));
		bytes_next = bytes_q + (is_pause ? 32'd4 : 32'd1);
	end

	// window memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= cmd.pulse;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_short) begin
			out_data <= {3'b000, STAT_SHORT, 32'd0, 1'b0, CNT_NONE, 32'd0};
			out_last <= 1'b1;
		end else if (load_emit) begin
			if (is_pause) begin
				out_data <= {3'b000, STAT_OK, bytes_next, turbo_q, CNT_PAUSE,
				             PAUSE_B3, PAUSE_B2, PAUSE_B1, PAUSE_B0};
			end else begin
				out_data <= {3'b000, STAT_OK, bytes_next, turbo_q, CNT_ONE,
				             24'd0, t_byte};
			end
			out_last <= emit_last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
			wr_ptr_q  <= '0;
			addr_q    <= '0;
			cnt_vld_q <= 1'b0;
			nt_q      <= '0;
			nn_q      <= '0;
			turbo_q   <= 1'b0;
			bytes_q   <= '0;
			eor_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_vld_q <= (state_q == BK_COUNT);

			if (load_emit || load_short) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			// write pointer: advance on store, rewind once the window is used or a recording ends short
			if (take) begin
				case (cmd.kind)
					CMD_STORE:  wr_ptr_q <= wr_ptr_q + 1'b1;
					CMD_REPLAY: wr_ptr_q <= '0;
					CMD_SHORT:  wr_ptr_q <= '0;
					default:    wr_ptr_q <= wr_ptr_q;
				endcase
			end

			// start the vote sweep
			if (take && cmd.kind == CMD_REPLAY) begin
				addr_q <= '0;
				nt_q   <= '0;
				nn_q   <= '0;
				eor_q  <= cmd.eor;
			end else if (state_q == BK_COUNT) begin
				if (addr_q != ADDR_LAST) begin
					addr_q <= addr_q + 1'b1;
				end
			end

			if (cnt_vld_q) begin
				nt_q <= nt_d;
				nn_q <= nn_d;
			end

			// decide speed once the last vote is in
			if (state_q == BK_DECIDE) begin
				turbo_q <= (nt_d > nn_d);
				addr_q  <= '0;
			end

			if (load_emit && !emit_last) begin
				addr_q <= addr_q + 1'b1;
			end

			// running byte total; clear the recording after its last result
			if (load_emit) begin
				if (emit_clear) begin
					bytes_q <= '0;
					turbo_q <= 1'b0;
				end else begin
					bytes_q <= bytes_next;
				end
			end
			if (load_short) begin
				bytes_q <= '0;
				turbo_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/tape_pulse_speed_detect_and_cleanup_top.sv]
// ============================================================================
// tape_pulse_speed_detect_and_cleanup_top
// Tape pulse speed detection and pulse-length cleanup with pause expansion.
// ============================================================================
// A streamed pulse is registered in the command queue and then in the result register.
// The pulse that fills the window starts a vote sweep over the held pulses, then WINDOW results,
// each fetched through the single read port of the window memory; no queue pop until the last is loaded.
// Input: one pulse per cycle while the 4-entry command queue has room.
// Reset: arst_n asynchronously clears all control state and loads register defaults.
module tape_pulse_speed_detect_and_cleanup_top #(
	parameter int WINDOW = tpsd_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // pulse_value
	input  logic                        s_axis_tlast,   // end_of_recording
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_byte_a, out_byte_b, out_byte_c, out_byte_d, byte_count, speed_is_turbo,
	// total_bytes, status, 3 bits zero fill
	output logic [tpsd_pkg::OUT_W-1:0]  m_axis_tdata,
	output logic                        m_axis_tlast,   // last_of_run
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);
	import tpsd_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic push, q_full, q_empty, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cleanup    <= RST_CLEANUP;
			cfg_q.cbm_short  <= RST_CBM_SHORT;
			cfg_q.cbm_medium <= RST_CBM_MEDIUM;
			cfg_q.cbm_long   <= RST_CBM_LONG;
			cfg_q.fast_short <= RST_FAST_SHORT;
			cfg_q.fast_long  <= RST_FAST_LONG;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLEANUP:    cfg_q.cleanup    <= cfg_data[0];
				CFG_CBM_SHORT:  cfg_q.cbm_short  <= cfg_data;
				CFG_CBM_MEDIUM: cfg_q.cbm_medium <= cfg_data;
				CFG_CBM_LONG:   cfg_q.cbm_long   <= cfg_data;
				CFG_FAST_SHORT: cfg_q.fast_short <= cfg_data;
				CFG_FAST_LONG:  cfg_q.fast_long  <= cfg_data;
				default: ;
			endcase
		end
	end

	tpsd_front #(.WINDOW(WINDOW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_pulse (s_axis_tdata),
		.in_eor   (s_axis_tlast),
		.q_full   (q_full),
		.push     (push),
		.cmd      (front_cmd)
	);

	tpsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (queue_cmd),
		.empty    (q_empty)
	);

	tpsd_back #(.WINDOW(WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.cmd       (queue_cmd),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
